/* rtl/percent_url_decoder_defines.svh */
// ----------------------------------------------------------------------------
// percent_url_decoder assertion macros
// shared concurrent assertion forms for the decoder
// ----------------------------------------------------------------------------
`ifndef PERCENT_URL_DECODER_DEFINES_SVH
`define PERCENT_URL_DECODER_DEFINES_SVH

// same-cycle implication
`define PUD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PUD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pud_pkg.sv */
// ----------------------------------------------------------------------------
// pud_pkg
// types, character codes and helpers for the percent url decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pud_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_MINUS   = 8'h2D;

  typedef enum logic [1:0] {
    ERR_OK         = 2'd0,
    ERR_INCOMPLETE = 2'd1,
    ERR_INVALID    = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_OPEN  = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } pud_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    err_t       error_code;
  } pud_out_t;

  typedef struct packed {
    logic     emit;
    pud_out_t word;
  } pud_res_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.valid = 1'b0;
    h.value = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.valid = 1'b1;
      h.value = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      h.valid = 1'b1;
      h.value = c[3:0] + 4'd9;
    end
    return h;
  endfunction

endpackage

/* rtl/pud_core.sv */
// ----------------------------------------------------------------------------
// pud_core
// escape state and combinational decode of one word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "percent_url_decoder_defines.svh"

module pud_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  pud_pkg::pud_in_t in_word,
  output pud_pkg::pud_res_t res
);

  pud_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]      digit_r, digit_nxt;
  logic            minus_r, minus_nxt;
  logic            failed_r, failed_nxt;
  pud_pkg::hex_t   hex;
  logic [7:0]      b;
  logic            last;

  assign b    = in_word.in_byte;
  assign last = in_word.in_last;
  assign hex  = pud_pkg::hex_decode(b);

  always_comb begin
    res.emit            = 1'b0;
    res.word.out_byte   = b;
    res.word.out_last   = last;
    res.word.error_code = pud_pkg::ERR_OK;
    phase_nxt           = phase_r;
    digit_nxt           = digit_r;
    minus_nxt           = minus_r;
    failed_nxt          = failed_r;
    if (!failed_r) begin
      case (phase_r)
        pud_pkg::PH_PLAIN: begin
          if (b == pud_pkg::CH_PERCENT) begin
            if (last) begin
              res.emit            = 1'b1;
              res.word.out_byte   = 8'h00;
              res.word.error_code = pud_pkg::ERR_INCOMPLETE;
            end else begin
              phase_nxt = pud_pkg::PH_OPEN;
            end
          end else if (b == pud_pkg::CH_PLUS) begin
            res.emit          = 1'b1;
            res.word.out_byte = pud_pkg::CH_SPACE;
          end else begin
            res.emit = 1'b1;
          end
        end
        pud_pkg::PH_OPEN: begin
          if (last) begin
            res.emit            = 1'b1;
            res.word.out_byte   = 8'h00;
            res.word.error_code = pud_pkg::ERR_INCOMPLETE;
          end else if (hex.valid) begin
            digit_nxt = hex.value;
            minus_nxt = 1'b0;
            phase_nxt = pud_pkg::PH_DIGIT;
          end else if (b == pud_pkg::CH_MINUS) begin
            digit_nxt = 4'h0;
            minus_nxt = 1'b1;
            phase_nxt = pud_pkg::PH_DIGIT;
          end else begin
            res.emit            = 1'b1;
            res.word.out_byte   = 8'h00;
            res.word.error_code = pud_pkg::ERR_INVALID;
            phase_nxt           = pud_pkg::PH_PLAIN;
            failed_nxt          = 1'b1;
          end
        end
        pud_pkg::PH_DIGIT: begin
          res.emit  = 1'b1;
          phase_nxt = pud_pkg::PH_PLAIN;
          if (minus_r) begin
            minus_nxt = 1'b0;
            if (hex.valid) begin
              res.word.out_byte = 8'h00 - {4'h0, hex.value};
            end else begin
              res.word.out_byte   = 8'h00;
              res.word.error_code = pud_pkg::ERR_INVALID;
              failed_nxt          = !last;
            end
          end else if (hex.valid) begin
            res.word.out_byte = {digit_r, hex.value};
          end else begin
            res.word.out_byte = {4'h0, digit_r};
          end
        end
        default: begin
          phase_nxt = pud_pkg::PH_PLAIN;
        end
      endcase
    end
    if (last) begin
      phase_nxt  = pud_pkg::PH_PLAIN;
      digit_nxt  = 4'h0;
      minus_nxt  = 1'b0;
      failed_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= pud_pkg::PH_PLAIN;
      digit_r  <= 4'h0;
      minus_r  <= 1'b0;
      failed_r <= 1'b0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      digit_r  <= digit_nxt;
      minus_r  <= minus_nxt;
      failed_r <= failed_nxt;
    end
  end

  `PUD_ASSERT_NEXT(a_last_clears, fire && last, phase_r == pud_pkg::PH_PLAIN && !failed_r && !minus_r, "state not cleared after last word")
  `PUD_ASSERT_NOW(a_failed_plain, failed_r, phase_r == pud_pkg::PH_PLAIN, "failed while inside an escape")
  `PUD_ASSERT_NOW(a_failed_silent, failed_r, !res.emit, "result while swallowing")
  `PUD_ASSERT_NOW(a_incomplete_last, res.emit && res.word.error_code == pud_pkg::ERR_INCOMPLETE, res.word.out_last && res.word.out_byte == 8'h00, "incomplete error off the last word")

endmodule

/* rtl/percent_url_decoder.sv */
// ----------------------------------------------------------------------------
// percent_url_decoder
// form url decoder: '+' to space, percent escapes to bytes, error reporting
// ----------------------------------------------------------------------------
// usage:
//   in_valid/in_stall/in_word carry one encoded byte per word, in_last
//   marking the final byte of a string. out_valid/out_stall/out_word carry
//   decoded words with out_last and error_code.
//   a '%' and a first escape byte that is a hex digit or '-' give no word;
//   the decoded byte comes with the second escape byte. after an error
//   the rest of the string up to its last byte is swallowed.
// path: a word accepted into the input register is decoded into the
//   output register and offered on out_word from there.
// throughput: one word per cycle while no stall holds it, set by the input
//   register feeding the decode logic and the output register.
// stall: while out_stall holds a waiting result, words that give no result
//   still drain; a word that gives a result waits in the input register and
//   in_stall rises.
// reset: rst_n low for one clock empties both registers and returns the
//   escape state to plain text.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module percent_url_decoder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pud_pkg::pud_in_t  in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output pud_pkg::pud_out_t out_word
);

  logic              s1_valid_r, s1_valid_nxt;
  pud_pkg::pud_in_t  s1_word_r;
  logic              out_valid_r, out_valid_nxt;
  pud_pkg::pud_out_t out_word_r;
  pud_pkg::pud_res_t res;
  logic              out_free;
  logic              s1_fire;
  logic              in_accept;

  pud_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (s1_fire),
    .in_word (s1_word_r),
    .res     (res)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && (!res.emit || out_free);
  assign in_stall  = s1_valid_r && !s1_fire;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r && out_stall;
    if (s1_fire && res.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_word_r <= in_word;
    end
    if (s1_fire && res.emit) begin
      out_word_r <= res.word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
